// ===== sv/cabir_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and control bundles for the cabinet impulse-response convolver.
package cabir_pkg;

  localparam int DATA_W       = 16;
  localparam int IDX_W        = 6;
  localparam int TAP_W        = 7;
  localparam int FRAC_W       = 15;
  localparam int MAX_TAPS_DEF = 64;
  localparam int ROUND_BIAS   = 16384;

  typedef logic signed [DATA_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef struct packed {
    logic clear;
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic term_en;
  } mac_ctrl_t;

endpackage

// ===== sv/cabir_if.sv =====
`timescale 1ns / 1ps
// Request channel interfaces for the input items and the filtered results.
interface cabir_in_if import cabir_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        opcode;
  sample_t     sample_in;
  logic [IDX_W-1:0] coef_index;
  sample_t     coef_value;

  modport source (output valid, output opcode, output sample_in, output coef_index,
                  output coef_value, input ready);
  modport sink (input valid, input opcode, input sample_in, input coef_index,
                input coef_value, output ready);
endinterface

interface cabir_out_if import cabir_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== sv/cabir_cell.sv =====
`timescale 1ns / 1ps
// One tap cell: holds a coefficient and a history sample and passes them along the ring.
module cabir_cell import cabir_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       coef_we,
  input  sample_t    coef_wdata,
  input  sample_t    left_samp,
  input  sample_t    right_coef,
  input  sample_t    right_samp,
  output sample_t    coef_q,
  output sample_t    samp_q
);

  sample_t coef_r;
  sample_t samp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      samp_r <= '0;
    end else begin
      if (ctrl.clear) begin
        samp_r <= '0;
      end else if (ctrl.shift) begin
        samp_r <= left_samp;
      end else if (ctrl.rotate) begin
        samp_r <= right_samp;
      end
      if (coef_we) begin
        coef_r <= coef_wdata;
      end else if (ctrl.rotate) begin
        coef_r <= right_coef;
      end
    end
  end

  assign coef_q = coef_r;
  assign samp_q = samp_r;

endmodule

// ===== sv/cabir_mac.sv =====
`timescale 1ns / 1ps
// Multiply-accumulate unit with Q1.15 rounding and saturation of the sum.
module cabir_mac import cabir_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mac_ctrl_t ctrl,
  input  sample_t   coef,
  input  sample_t   samp,
  output sample_t   result
);

  localparam int ACC_W = 2 * DATA_W + $clog2(MAX_TAPS) + 1;
  localparam int Q_W   = ACC_W + 1 - FRAC_W;

  logic signed [2*DATA_W-1:0] prod_r;
  logic                       prod_en_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W:0]      biased;
  logic signed [Q_W-1:0]      quot;

  always_ff @(posedge clk) begin
    prod_r <= coef * samp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_en_r <= 1'b0;
      acc_r     <= '0;
    end else if (ctrl.clear) begin
      prod_en_r <= 1'b0;
      acc_r     <= '0;
    end else begin
      prod_en_r <= ctrl.term_en;
      if (prod_en_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign biased = (ACC_W+1)'(acc_r) + (ACC_W+1)'(ROUND_BIAS);
  assign quot   = biased[ACC_W:FRAC_W];

  always_comb begin
    if (quot > Q_W'(SAMPLE_MAX)) begin
      result = SAMPLE_MAX;
    end else if (quot < Q_W'(SAMPLE_MIN)) begin
      result = SAMPLE_MIN;
    end else begin
      result = quot[DATA_W-1:0];
    end
  end

endmodule

// ===== sv/cabinet_ir_fir_convolver.sv =====
`timescale 1ns / 1ps
// Top level of the cabinet impulse-response convolver: tap cell ring, sequencer and MAC.
//
//   Channel   Dir  Payload                                       Transfer
//   in_ch     in   opcode, sample_in, coef_index, coef_value     valid and ready high
//   out_ch    out  sample_out                                    valid and ready high
//   cfg_*     in   cfg_wdata (tap_count)                         cfg_we high
//
// An audio request goes through RUN, DRAIN and FINISH before the next one can be taken, as
// the tap ring rotates once through all MAX_TAPS cells into one MAC; FINISH waits on out_ch.
// A passthrough request (tap_count zero) skips to FINISH; a coefficient write stays idle.
// Reset clears every cell at once, so there is no clearing pass after reset.
// A finished result waits in the output register while the next request is accepted.
module cabinet_ir_fir_convolver import cabir_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  cabir_in_if.sink         in_ch,
  cabir_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [TAP_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int CMP_W = (TAP_W > CNT_W) ? TAP_W : CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pass_r;
  sample_t          x_r;
  logic             out_valid_r;
  sample_t          out_data_r;
  logic [TAP_W-1:0] tap_r;

  logic [CMP_W-1:0] tap_ext;
  logic [CMP_W-1:0] n_eff;
  logic             has_taps;
  logic             accept;
  logic             audio_go;
  logic             coef_ok;
  logic             hist_clear;
  cell_ctrl_t       cell_ctrl;
  mac_ctrl_t        mac_ctrl;
  sample_t          mac_result;
  sample_t          cell_coef [MAX_TAPS];
  sample_t          cell_samp [MAX_TAPS];

  assign tap_ext  = CMP_W'(tap_r);
  assign n_eff    = (tap_ext > CMP_W'(MAX_TAPS)) ? CMP_W'(MAX_TAPS) : tap_ext;
  assign has_taps = (n_eff != '0);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign audio_go    = accept && (in_ch.opcode == OP_SAMPLE);
  assign coef_ok     = accept && (in_ch.opcode == OP_COEF) && (int'(in_ch.coef_index) < MAX_TAPS);
  assign hist_clear  = cfg_we || coef_ok;

  assign cell_ctrl.clear  = hist_clear;
  assign cell_ctrl.shift  = audio_go && has_taps;
  assign cell_ctrl.rotate = (state_r == ST_RUN);

  assign mac_ctrl.clear   = audio_go;
  assign mac_ctrl.term_en = (state_r == ST_RUN) && (CMP_W'(cnt_r) < n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (cfg_we) begin
      tap_r <= cfg_wdata;
    end
  end

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    localparam int NEXT = (i + 1) % MAX_TAPS;
    sample_t left_samp;
    logic    coef_sel;

    if (i == 0) begin : g_head
      assign left_samp = in_ch.sample_in;
    end else begin : g_body
      assign left_samp = cell_samp[i-1];
    end

    assign coef_sel = coef_ok && (int'(in_ch.coef_index) == i);

    cabir_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .coef_we    (coef_sel),
      .coef_wdata (in_ch.coef_value),
      .left_samp  (left_samp),
      .right_coef (cell_coef[NEXT]),
      .right_samp (cell_samp[NEXT]),
      .coef_q     (cell_coef[i]),
      .samp_q     (cell_samp[i])
    );
  end

  cabir_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .coef   (cell_coef[0]),
    .samp   (cell_samp[0]),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (audio_go) begin
            x_r    <= in_ch.sample_in;
            pass_r <= !has_taps;
            cnt_r  <= '0;
            state_r <= has_taps ? ST_RUN : ST_FINISH;
          end
        end
        ST_RUN: begin
          if (cnt_r == CNT_W'(MAX_TAPS - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= pass_r ? x_r : mac_result;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

`ifndef ASSERT_OFF
  a_run_to_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r == CNT_W'(MAX_TAPS - 1)) |=> (state_r == ST_DRAIN))
    else $error("sequencer did not leave the rotation after the last tap");

  a_drain_to_finish : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (state_r == ST_FINISH))
    else $error("drain cycle not followed by result stage");

  a_ring_home : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0))
    else $error("tap ring not at home position while idle");

  a_coef_clears : assert property (@(posedge clk) disable iff (!rst_n)
    coef_ok |=> (cell_samp[0] == '0))
    else $error("coefficient write did not clear the history");

  a_sample_enters : assert property (@(posedge clk) disable iff (!rst_n)
    audio_go && has_taps && !cfg_we |=> (cell_samp[0] == $past(in_ch.sample_in)))
    else $error("new sample did not enter the head cell");
`endif

endmodule
